>>> rtl/srbb_pkg.sv
// Shared types and constants for the sample ring buffer burst reader.
`timescale 1ns / 1ps

package srbb_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int DATA_W        = 8;
    localparam int LEN_W         = 8;
    localparam int RCOUNT_W      = 6;

    localparam logic FUNC_STORE = 1'b0;
    localparam logic FUNC_READ  = 1'b1;

    typedef enum logic [0:0] {
        S_IDLE,
        S_BURST
    } srbb_state_t;

    // controller -> datapath
    typedef struct packed {
        logic store;       // write sample at tail
        logic start_read;  // latch burst length
        logic issue_read;  // read store at head, advance head
        logic load_empty;  // present the nothing-read result
    } srbb_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic count_zero;  // burst delivers no bytes
        logic remain_zero; // all reads of the burst issued
        logic rd_pending;  // read data waits at the store output
        logic out_free;    // output register can load this cycle
    } srbb_sts_t;

endpackage

>>> rtl/srbb_in_if.sv
// Input channel: store and burst read request transactions.
`timescale 1ns / 1ps

interface srbb_in_if;
    logic                        valid;
    logic                        ready;
    logic                        func;
    logic [srbb_pkg::DATA_W-1:0] sample_byte;
    logic [srbb_pkg::LEN_W-1:0]  req_length;

    modport source (output valid, func, sample_byte, req_length, input ready);
    modport sink   (input valid, func, sample_byte, req_length, output ready);
endinterface

>>> rtl/srbb_out_if.sv
// Output channel: one transaction per delivered byte, or one nothing-read transaction for an empty burst.
`timescale 1ns / 1ps

interface srbb_out_if;
    logic                          valid;
    logic                          ready;
    logic [srbb_pkg::DATA_W-1:0]   out_byte;
    logic                          is_last;
    logic [srbb_pkg::RCOUNT_W-1:0] returned_count;
    logic                          nothing_read;

    modport source (output valid, out_byte, is_last, returned_count, nothing_read,
                    input ready);
    modport sink   (input valid, out_byte, is_last, returned_count, nothing_read,
                    output ready);
endinterface

>>> rtl/sample_ring_buffer_burst_read_unit.sv
// Top level of the sample ring buffer with burst read.
//
//   channel    dir  payload                                          transaction
//   in_chan    in   func, sample_byte, req_length                    valid & ready
//   out_chan   out  out_byte, is_last, returned_count, nothing_read  valid & ready
//
// A store transaction leaves the unit idle, so the next one is accepted right after.
// A read burst of n bytes runs through the request, one store read per cycle
// through the registered RAM port while out_chan does not stall, the last byte
// leaving the RAM, and the return to idle. An empty burst presents the
// nothing-read result and returns to idle. Reset clears both pointers; the store
// itself is not cleared and needs no pass. Stalls on out_chan hold the burst, and
// in_chan stays blocked until the last byte has reached the output register.
`timescale 1ns / 1ps

module sample_ring_buffer_burst_read_unit #(
    parameter int DEPTH = srbb_pkg::DEPTH_DEFAULT
) (
    input logic       clk,
    input logic       rst_n,
    srbb_in_if.sink   in_chan,
    srbb_out_if.source out_chan
);

    srbb_pkg::srbb_cmd_t cmd;
    srbb_pkg::srbb_sts_t sts;

    // Controller decides when transactions are taken and when the store is read.
    srbb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_chan.valid),
        .in_func  (in_chan.func),
        .in_ready (in_chan.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath owns pointers, the sample RAM and the output register.
    srbb_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .sample_byte    (in_chan.sample_byte),
        .req_length     (in_chan.req_length),
        .out_valid      (out_chan.valid),
        .out_ready      (out_chan.ready),
        .out_byte       (out_chan.out_byte),
        .is_last        (out_chan.is_last),
        .returned_count (out_chan.returned_count),
        .nothing_read   (out_chan.nothing_read)
    );

endmodule

>>> rtl/srbb_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module srbb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/srbb_ctrl.sv
// Controller state machine: accepts transactions and sequences read bursts.
`timescale 1ns / 1ps

module srbb_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_func,
    output logic                in_ready,
    input  srbb_pkg::srbb_sts_t sts,
    output srbb_pkg::srbb_cmd_t cmd
);

    srbb_pkg::srbb_state_t state_reg;
    srbb_pkg::srbb_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= srbb_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            srbb_pkg::S_IDLE:
            begin
                if (in_valid && in_func == srbb_pkg::FUNC_READ)
                begin
                    state_next = srbb_pkg::S_BURST;
                end
            end
            srbb_pkg::S_BURST:
            begin
                if (sts.count_zero)
                begin
                    if (sts.out_free)
                    begin
                        state_next = srbb_pkg::S_IDLE;
                    end
                end
                else if (sts.remain_zero && !sts.rd_pending)
                begin
                    state_next = srbb_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = srbb_pkg::S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        case (state_reg)
            srbb_pkg::S_IDLE:
            begin
                in_ready       = 1'b1;
                cmd.store      = in_valid && (in_func == srbb_pkg::FUNC_STORE);
                cmd.start_read = in_valid && (in_func == srbb_pkg::FUNC_READ);
            end
            srbb_pkg::S_BURST:
            begin
                cmd.load_empty = sts.count_zero && sts.out_free;
                cmd.issue_read = !sts.count_zero && !sts.remain_zero
                                 && (!sts.rd_pending || sts.out_free);
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

>>> rtl/srbb_dp.sv
// Datapath: head/tail pointers, sample store, burst counters, output register.
`timescale 1ns / 1ps

module srbb_dp #(
    parameter int DEPTH = srbb_pkg::DEPTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  srbb_pkg::srbb_cmd_t           cmd,
    output srbb_pkg::srbb_sts_t           sts,
    input  logic [srbb_pkg::DATA_W-1:0]   sample_byte,
    input  logic [srbb_pkg::LEN_W-1:0]    req_length,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [srbb_pkg::DATA_W-1:0]   out_byte,
    output logic                          is_last,
    output logic [srbb_pkg::RCOUNT_W-1:0] returned_count,
    output logic                          nothing_read
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = PTR_W + 1;

    logic [PTR_W-1:0]              wp_reg, wp_next;
    logic [PTR_W-1:0]              rp_reg, rp_next;
    logic [srbb_pkg::RCOUNT_W-1:0] remaining_reg, remaining_next;
    logic [srbb_pkg::RCOUNT_W-1:0] burst_count_reg, burst_count_next;
    logic                          rd_pending_reg, rd_pending_next;
    logic                          pend_last_reg, pend_last_next;
    logic                          out_valid_reg, out_valid_next;
    logic [srbb_pkg::DATA_W-1:0]   out_byte_reg;
    logic                          is_last_reg;
    logic [srbb_pkg::RCOUNT_W-1:0] rcount_reg;
    logic                          nothing_reg;

    logic [CNT_W-1:0]              fill;
    logic [srbb_pkg::LEN_W-1:0]    fill_wide;
    logic [srbb_pkg::LEN_W-1:0]    burst_len;
    logic [srbb_pkg::DATA_W-1:0]   rd_data;
    logic                          out_free;
    logic                          move_data;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(DEPTH - 1))
        begin
            return '0;
        end
        return p + PTR_W'(1);
    endfunction

    srbb_ram #(
        .WIDTH (srbb_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (cmd.store),
        .wr_addr (wp_reg),
        .wr_data (sample_byte),
        .rd_en   (cmd.issue_read),
        .rd_addr (rp_reg),
        .rd_data (rd_data)
    );

    // fill count, modulo DEPTH
    always_comb
    begin
        if (wp_reg >= rp_reg)
        begin
            fill = {1'b0, wp_reg} - {1'b0, rp_reg};
        end
        else
        begin
            fill = {1'b0, wp_reg} + CNT_W'(DEPTH) - {1'b0, rp_reg};
        end
        fill_wide = srbb_pkg::LEN_W'(fill);
        burst_len = (req_length < fill_wide) ? req_length : fill_wide;
    end

    assign out_free  = !out_valid_reg || out_ready;
    assign move_data = rd_pending_reg && out_free;

    assign sts.count_zero  = (burst_count_reg == '0);
    assign sts.remain_zero = (remaining_reg == '0);
    assign sts.rd_pending  = rd_pending_reg;
    assign sts.out_free    = out_free;

    always_comb
    begin
        wp_next          = cmd.store ? ptr_inc(wp_reg) : wp_reg;
        rp_next          = cmd.issue_read ? ptr_inc(rp_reg) : rp_reg;
        remaining_next   = remaining_reg;
        burst_count_next = burst_count_reg;
        pend_last_next   = pend_last_reg;
        if (cmd.start_read)
        begin
            remaining_next   = srbb_pkg::RCOUNT_W'(burst_len);
            burst_count_next = srbb_pkg::RCOUNT_W'(burst_len);
        end
        else if (cmd.issue_read)
        begin
            remaining_next = remaining_reg - srbb_pkg::RCOUNT_W'(1);
            pend_last_next = (remaining_reg == srbb_pkg::RCOUNT_W'(1));
        end

        if (cmd.issue_read)
        begin
            rd_pending_next = 1'b1;
        end
        else if (move_data)
        begin
            rd_pending_next = 1'b0;
        end
        else
        begin
            rd_pending_next = rd_pending_reg;
        end

        if (move_data || cmd.load_empty)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg          <= '0;
            rp_reg          <= '0;
            remaining_reg   <= '0;
            burst_count_reg <= '0;
            rd_pending_reg  <= 1'b0;
            pend_last_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            wp_reg          <= wp_next;
            rp_reg          <= rp_next;
            remaining_reg   <= remaining_next;
            burst_count_reg <= burst_count_next;
            rd_pending_reg  <= rd_pending_next;
            pend_last_reg   <= pend_last_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // output payload, no reset
    always_ff @(posedge clk)
    begin
        if (move_data)
        begin
            out_byte_reg <= rd_data;
            is_last_reg  <= pend_last_reg;
            rcount_reg   <= burst_count_reg;
            nothing_reg  <= 1'b0;
        end
        else if (cmd.load_empty)
        begin
            out_byte_reg <= '0;
            is_last_reg  <= 1'b1;
            rcount_reg   <= '0;
            nothing_reg  <= 1'b1;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_byte       = out_byte_reg;
    assign is_last        = is_last_reg;
    assign returned_count = rcount_reg;
    assign nothing_read   = nothing_reg;

    a_issue_needs_remaining: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue_read |-> remaining_reg != '0)
        else $error("read issued with no bytes left in burst");

    a_pending_not_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_pending_reg && !out_free) |=> (rd_pending_reg && $stable(rd_data)))
        else $error("pending store data lost under stall");

    a_empty_not_with_data: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_empty |-> !rd_pending_reg)
        else $error("nothing-read result while data pending");

    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (rp_reg <= PTR_W'(DEPTH - 1)) && (wp_reg <= PTR_W'(DEPTH - 1)))
        else $error("pointer beyond depth");

endmodule
